>>> rtl/gdfw_pkg.sv
package gdfw_pkg;

  localparam int NODE_W      = 6;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;

  localparam int NODES_DEFAULT      = 64;
  localparam int MAX_DEGREE_DEFAULT = 16;

  localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN_WALK = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_VISITED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LIST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_NODE_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_NODE = 1'd1;

  localparam logic [CFG_DATA_W-1:0] NODE_COUNT_RESET = 7'd64;

  typedef struct packed {
    logic                in_ready;
    logic                latch_in;
    logic                deg_rd_a;
    logic                deg_rd_b;
    logic                deg_rd_cur;
    logic                cap_a;
    logic                cap_b;
    logic                cap_deg;
    logic                wr_a;
    logic                wr_b;
    logic                clear_deg;
    logic                clear_visited;
    logic                start_walk;
    logic                nbr_rd;
    logic                push;
    logic                pop_rd;
    logic                pop_cap;
    logic                emit;
    logic                emit_pend;
    logic                emit_last;
    logic [STATUS_W-1:0] emit_status;
  } gdfw_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            range_bad;
    logic            start_bad;
    logic            deg_full;
    logic            self_loop;
    logic            pos_lt_deg;
    logic            sp_zero;
    logic            nb_visited;
    logic            out_free;
  } gdfw_stat_t;

endpackage

>>> rtl/gdfw_in_if.sv
interface gdfw_in_if;
  import gdfw_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source (output valid, output opcode, output node_a, output node_b, input ready);
  modport sink   (input valid, input opcode, input node_a, input node_b, output ready);
endinterface

>>> rtl/gdfw_out_if.sv
interface gdfw_out_if;
  import gdfw_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NODE_W-1:0]   visited_node;
  logic                last;

  modport source (output valid, output status, output visited_node, output last, input ready);
  modport sink   (input valid, input status, input visited_node, input last, output ready);
endinterface

>>> rtl/gdfw_ram.sv
module gdfw_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/gdfw_ctrl.sv
module gdfw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  gdfw_pkg::gdfw_stat_t stat,
  output gdfw_pkg::gdfw_cmd_t  cmd
);
  import gdfw_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_RD_B     = 4'd2;
  localparam logic [3:0] S_CAP_B    = 4'd3;
  localparam logic [3:0] S_WR_A     = 4'd4;
  localparam logic [3:0] S_WR_B     = 4'd5;
  localparam logic [3:0] S_EMIT     = 4'd6;
  localparam logic [3:0] S_W_DEG    = 4'd7;
  localparam logic [3:0] S_W_CAP    = 4'd8;
  localparam logic [3:0] S_W_STEP   = 4'd9;
  localparam logic [3:0] S_W_NB     = 4'd10;
  localparam logic [3:0] S_W_POP    = 4'd11;
  localparam logic [3:0] S_W_END    = 4'd12;

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [STATUS_W-1:0] code;
  logic [STATUS_W-1:0] code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_DONE;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    code_next  = code;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_ADD_EDGE: begin
            if (stat.range_bad) begin
              code_next  = ST_RANGE;
              state_next = S_EMIT;
            end else begin
              cmd.deg_rd_a = 1'b1;
              state_next   = S_RD_B;
            end
          end
          OP_RUN_WALK: begin
            cmd.clear_visited = 1'b1;
            if (stat.start_bad) begin
              code_next  = ST_RANGE;
              state_next = S_EMIT;
            end else begin
              cmd.start_walk = 1'b1;
              state_next     = S_W_DEG;
            end
          end
          OP_CLEAR: begin
            cmd.clear_deg = 1'b1;
            code_next     = ST_DONE;
            state_next    = S_EMIT;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_RD_B: begin
        cmd.cap_a    = 1'b1;
        cmd.deg_rd_b = 1'b1;
        state_next   = S_CAP_B;
      end
      S_CAP_B: begin
        cmd.cap_b  = 1'b1;
        state_next = S_WR_A;
      end
      S_WR_A: begin
        if (stat.deg_full) begin
          code_next  = ST_LIST_FULL;
          state_next = S_EMIT;
        end else begin
          cmd.wr_a  = 1'b1;
          code_next = ST_DONE;
          if (stat.self_loop) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_WR_B;
          end
        end
      end
      S_WR_B: begin
        cmd.wr_b   = 1'b1;
        code_next  = ST_DONE;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = code;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_W_DEG: begin
        cmd.deg_rd_cur = 1'b1;
        state_next     = S_W_CAP;
      end
      S_W_CAP: begin
        cmd.cap_deg = 1'b1;
        state_next  = S_W_STEP;
      end
      S_W_STEP: begin
        if (stat.pos_lt_deg) begin
          cmd.nbr_rd = 1'b1;
          state_next = S_W_NB;
        end else if (stat.sp_zero) begin
          state_next = S_W_END;
        end else begin
          cmd.pop_rd = 1'b1;
          state_next = S_W_POP;
        end
      end
      S_W_NB: begin
        if (stat.nb_visited) begin
          state_next = S_W_STEP;
        end else if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_VISITED;
          cmd.emit_pend   = 1'b1;
          cmd.push        = 1'b1;
          state_next      = S_W_DEG;
        end
      end
      S_W_POP: begin
        cmd.pop_cap = 1'b1;
        state_next  = S_W_DEG;
      end
      S_W_END: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_VISITED;
          cmd.emit_pend   = 1'b1;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/gdfw_dpath.sv
module gdfw_dpath #(
  parameter int NODES      = gdfw_pkg::NODES_DEFAULT,
  parameter int MAX_DEGREE = gdfw_pkg::MAX_DEGREE_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gdfw_pkg::gdfw_cmd_t               cmd,
  output gdfw_pkg::gdfw_stat_t              stat,
  input  logic                              cfg_we,
  input  logic [gdfw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [gdfw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [gdfw_pkg::OP_W-1:0]         in_opcode,
  input  logic [gdfw_pkg::NODE_W-1:0]       in_node_a,
  input  logic [gdfw_pkg::NODE_W-1:0]       in_node_b,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gdfw_pkg::STATUS_W-1:0]     out_status,
  output logic [gdfw_pkg::NODE_W-1:0]       out_node,
  output logic                              out_last
);
  import gdfw_pkg::*;

  localparam int USED      = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);
  localparam int NIW       = $clog2(USED);
  localparam int DW        = $clog2(MAX_DEGREE + 1);
  localparam int NBR_DEPTH = USED * MAX_DEGREE;
  localparam int NBR_AW    = $clog2(NBR_DEPTH);
  localparam int SW        = NIW + DW;

  logic [OP_W-1:0]       op_q;
  logic [NODE_W-1:0]     a_q;
  logic [NODE_W-1:0]     b_q;
  logic [CFG_DATA_W-1:0] node_count;
  logic [NODE_W-1:0]     start_node;
  logic [DW-1:0]         deg_a;
  logic [DW-1:0]         deg_b;
  logic [DW-1:0]         cur_deg;
  logic [NIW-1:0]        cur_node;
  logic [DW-1:0]         cur_pos;
  logic [NIW-1:0]        sp;
  logic [NIW-1:0]        pend;
  logic [USED-1:0]       visited;
  logic [USED-1:0]       deg_valid;
  logic                  deg_rd_vld;

  logic [NIW-1:0]        a_idx;
  logic [NIW-1:0]        b_idx;
  logic [NIW-1:0]        start_idx;
  logic                  deg_re;
  logic [NIW-1:0]        deg_raddr;
  logic [DW-1:0]         deg_rdata;
  logic [DW-1:0]         deg_eff;
  logic                  deg_we;
  logic [NIW-1:0]        deg_waddr;
  logic [DW-1:0]         deg_wdata;
  logic                  nbr_we;
  logic [NBR_AW-1:0]     nbr_waddr;
  logic [NIW-1:0]        nbr_wdata;
  logic [NBR_AW-1:0]     nbr_raddr;
  logic [NIW-1:0]        nb;
  logic [SW-1:0]         stk_rdata;

  function automatic logic [NBR_AW-1:0] nbr_addr(input logic [NIW-1:0] n,
                                                 input logic [DW-1:0] p);
    nbr_addr = NBR_AW'(NBR_AW'(n) * NBR_AW'(MAX_DEGREE) + NBR_AW'(p));
  endfunction

  function automatic logic in_range(input logic [NODE_W-1:0] x,
                                    input logic [CFG_DATA_W-1:0] cnt);
    in_range = ({1'b0, x} < cnt) && (32'(x) < NODES);
  endfunction

  assign a_idx     = a_q[NIW-1:0];
  assign b_idx     = b_q[NIW-1:0];
  assign start_idx = start_node[NIW-1:0];

  always_comb begin
    deg_re    = cmd.deg_rd_a | cmd.deg_rd_b | cmd.deg_rd_cur;
    deg_raddr = cmd.deg_rd_b ? b_idx : (cmd.deg_rd_cur ? cur_node : a_idx);
    deg_eff   = deg_rd_vld ? deg_rdata : '0;
    deg_we    = cmd.wr_a | cmd.wr_b;
    deg_waddr = cmd.wr_b ? b_idx : a_idx;
    deg_wdata = cmd.wr_b ? DW'(deg_b + 1'b1) : DW'(deg_a + 1'b1);
    nbr_we    = cmd.wr_a | cmd.wr_b;
    nbr_waddr = cmd.wr_b ? nbr_addr(b_idx, deg_b) : nbr_addr(a_idx, deg_a);
    nbr_wdata = cmd.wr_b ? a_idx : b_idx;
    nbr_raddr = nbr_addr(cur_node, cur_pos);
  end

  gdfw_ram #(.WIDTH(DW), .DEPTH(USED), .ADDR_W(NIW)) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .re    (deg_re),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  gdfw_ram #(.WIDTH(NIW), .DEPTH(NBR_DEPTH), .ADDR_W(NBR_AW)) u_nbr_ram (
    .clk   (clk),
    .we    (nbr_we),
    .waddr (nbr_waddr),
    .wdata (nbr_wdata),
    .re    (cmd.nbr_rd),
    .raddr (nbr_raddr),
    .rdata (nb)
  );

  gdfw_ram #(.WIDTH(SW), .DEPTH(USED), .ADDR_W(NIW)) u_stack_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (sp),
    .wdata ({cur_node, cur_pos}),
    .re    (cmd.pop_rd),
    .raddr (NIW'(sp - 1'b1)),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
      start_node <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count <= cfg_data;
        CFG_START_NODE: start_node <= cfg_data[NODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deg_valid <= '0;
      visited   <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_deg) begin
        deg_valid <= '0;
      end
      if (cmd.wr_a) begin
        deg_valid[a_idx] <= 1'b1;
      end
      if (cmd.wr_b) begin
        deg_valid[b_idx] <= 1'b1;
      end
      if (cmd.clear_visited) begin
        visited <= '0;
      end
      if (cmd.start_walk) begin
        visited[start_idx] <= 1'b1;
        sp                 <= '0;
      end
      if (cmd.push) begin
        visited[nb] <= 1'b1;
        sp          <= NIW'(sp + 1'b1);
      end
      if (cmd.pop_rd) begin
        sp <= NIW'(sp - 1'b1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q <= in_opcode;
      a_q  <= in_node_a;
      b_q  <= in_node_b;
    end
    if (deg_re) begin
      deg_rd_vld <= deg_valid[deg_raddr];
    end
    if (cmd.cap_a) begin
      deg_a <= deg_eff;
    end
    if (cmd.cap_b) begin
      deg_b <= deg_eff;
    end
    if (cmd.cap_deg) begin
      cur_deg <= deg_eff;
    end
    if (cmd.start_walk) begin
      cur_node <= start_idx;
      cur_pos  <= '0;
      pend     <= start_idx;
    end
    if (cmd.nbr_rd) begin
      cur_pos <= DW'(cur_pos + 1'b1);
    end
    if (cmd.push) begin
      cur_node <= nb;
      cur_pos  <= '0;
      pend     <= nb;
    end
    if (cmd.pop_cap) begin
      cur_node <= stk_rdata[SW-1:DW];
      cur_pos  <= stk_rdata[DW-1:0];
    end
    if (cmd.emit) begin
      out_status <= cmd.emit_status;
      out_node   <= cmd.emit_pend ? NODE_W'(pend) : '0;
      out_last   <= cmd.emit_last;
    end
  end

  always_comb begin
    stat            = '0;
    stat.op         = op_q;
    stat.range_bad  = !in_range(a_q, node_count) || !in_range(b_q, node_count);
    stat.start_bad  = !in_range(start_node, node_count);
    stat.deg_full   = (deg_a >= DW'(MAX_DEGREE)) || (deg_b >= DW'(MAX_DEGREE));
    stat.self_loop  = (a_q == b_q);
    stat.pos_lt_deg = (cur_pos < cur_deg);
    stat.sp_zero    = (sp == '0);
    stat.nb_visited = visited[nb];
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

>>> rtl/graph_depth_first_walk_unit.sv
// Depth-first walk over an undirected graph stored as per-node neighbor lists in RAM.
// Opcode 0 adds an edge and opcode 2 clears every list, and each produces one item.
// Opcode 1 walks from start_node and produces one item per visited node; the final
// one has last set. An out-of-range start_node gives one range item instead.
// The walk stalls while the output side holds a result. A new item is taken only
// after the previous one has issued all its results, and the output register lets
// that happen while the last result still waits to be taken.
module graph_depth_first_walk_unit #(
  parameter int NODES      = gdfw_pkg::NODES_DEFAULT,
  parameter int MAX_DEGREE = gdfw_pkg::MAX_DEGREE_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  gdfw_in_if.sink                          item_in,
  gdfw_out_if.source                       item_out,
  input  logic                             cfg_we,
  input  logic [gdfw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gdfw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gdfw_pkg::*;

  gdfw_cmd_t  cmd;
  gdfw_stat_t stat;

  assign item_in.ready = cmd.in_ready;

  gdfw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  gdfw_dpath #(.NODES(NODES), .MAX_DEGREE(MAX_DEGREE)) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_opcode  (item_in.opcode),
    .in_node_a  (item_in.node_a),
    .in_node_b  (item_in.node_b),
    .out_valid  (item_out.valid),
    .out_ready  (item_out.ready),
    .out_status (item_out.status),
    .out_node   (item_out.visited_node),
    .out_last   (item_out.last)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (rst) cmd.emit |-> stat.out_free)
    else $error("result issued over an undelivered item");

  a_push_depth: assert property (@(posedge clk) disable iff (rst) cmd.push |=> !stat.sp_zero)
    else $error("stack empty right after a push");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_rd |-> !stat.sp_zero)
    else $error("pop from an empty stack");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.in_ready |-> !(cmd.emit || cmd.push || cmd.wr_a || cmd.wr_b))
    else $error("datapath activity while waiting for an item");

endmodule
